// ===== src/pcs_pkg.sv =====
package pcs_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int DT_W      = 24;
	localparam int LIM_W     = 31;
	localparam int PROD_W    = 66;

	localparam logic [DT_W-1:0]   DT_MIN    = 24'd17;
	localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
	localparam logic signed [33:0] FULL_TURN = 34'sd23592960;

	localparam logic [2:0] REG_FLAGS    = 3'd0;
	localparam logic [2:0] REG_GAIN_P   = 3'd1;
	localparam logic [2:0] REG_GAIN_I   = 3'd2;
	localparam logic [2:0] REG_GAIN_D   = 3'd3;
	localparam logic [2:0] REG_INT_LIM  = 3'd4;
	localparam logic [2:0] REG_OUT_LIM  = 3'd5;
	localparam logic [2:0] REG_DB_WIDTH = 3'd6;
	localparam logic [2:0] REG_ERR_LIM  = 3'd7;

	typedef struct packed {
		logic                     incr;
		logic                     wrap;
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic [LIM_W-1:0]         int_lim;
		logic [LIM_W-1:0]         out_lim;
		logic [LIM_W-1:0]         db_width;
		logic [LIM_W-1:0]         err_lim;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] drive;
		logic              rejected;
	} res_t;

	// signed 32-bit result from a magnitude and a sign, saturating
	function automatic logic [DATA_W-1:0] sat_mag(input logic [PROD_W-1:0] m, input logic neg);
		logic [DATA_W-1:0] r;
		if (neg) begin
			if (m > 66'h80000000)
				r = 32'h80000000;
			else
				r = ~m[DATA_W-1:0] + 32'd1;
		end else begin
			if (m > 66'h7fffffff)
				r = 32'h7fffffff;
			else
				r = m[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/pcs_mul.sv =====
module pcs_mul import pcs_pkg::*; (
	input  logic                     clk,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [33:0]       b,
	input  logic                     sh24,
	output logic [DATA_W-1:0]        res,
	output logic [63:0]              prod,
	output logic                     neg
);

	logic [DATA_W-1:0] a_u, a_mag;
	logic [33:0]       b_u, b_mag;

	logic [DATA_W-1:0] a_mag_s1;
	logic [33:0]       b_mag_s1;
	logic              neg_s1, sh24_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2, sh24_s2;

	always_comb begin
		a_u   = a;
		b_u   = b;
		a_mag = a[DATA_W-1] ? (~a_u + 32'd1) : a_u;
		b_mag = b[33] ? (~b_u + 34'd1) : b_u;
	end

	always_ff @(posedge clk) begin
		a_mag_s1 <= a_mag;
		b_mag_s1 <= b_mag;
		neg_s1   <= a[DATA_W-1] ^ b[33];
		sh24_s1  <= sh24;
		prod_s2  <= PROD_W'(a_mag_s1) * PROD_W'(b_mag_s1);
		neg_s2   <= neg_s1;
		sh24_s2  <= sh24_s1;
	end

	assign res  = sat_mag(sh24_s2 ? (prod_s2 >> DT_W) : (prod_s2 >> FRAC_BITS), neg_s2);
	assign prod = prod_s2[63:0];
	assign neg  = neg_s2;

endmodule

// ===== src/pcs_div.sv =====
module pcs_div import pcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       num,
	input  logic              neg,
	input  logic [DT_W-1:0]   den,
	output logic              busy,
	output logic [DATA_W-1:0] res
);

	// quotient of num * 2^8 / den, one bit a cycle
	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [DT_W-1:0]   rem_q, den_q;
	logic [31:0]       lo_q, quo_q;
	logic              ovf_q, neg_q;
	logic [DT_W:0]     trial;
	logic              ge;
	logic              ovf_now;

	assign trial   = {rem_q, lo_q[31]};
	assign ge      = trial >= {1'b0, den_q};
	assign ovf_now = num[63:24] >= {16'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !ovf_now;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			den_q <= den;
			ovf_q <= ovf_now;
			quo_q <= '0;
			rem_q <= num[47:24];
			lo_q  <= {num[23:0], 8'b0};
		end else if (busy_q) begin
			rem_q <= ge ? DT_W'(trial - {1'b0, den_q}) : trial[DT_W-1:0];
			quo_q <= {quo_q[30:0], ge};
			lo_q  <= {lo_q[30:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign res  = ovf_q ? sat_mag({PROD_W{1'b1}}, neg_q) : sat_mag(PROD_W'(quo_q), neg_q);

endmodule

// ===== src/pcs_seq.sv =====
module pcs_seq import pcs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] meas,
	input  logic signed [DATA_W-1:0] targ,
	input  logic [DT_W-1:0]          dt,
	output logic                     res_valid,
	input  logic                     res_ready,
	output res_t                     res
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_WRAP  = 4'd2;
	localparam logic [3:0] ST_WFIN  = 4'd3;
	localparam logic [3:0] ST_CHECK = 4'd4;
	localparam logic [3:0] ST_SOFT  = 4'd5;
	localparam logic [3:0] ST_DIFF  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_DIVW  = 4'd8;
	localparam logic [3:0] ST_INT   = 4'd9;
	localparam logic [3:0] ST_ADD2  = 4'd10;
	localparam logic [3:0] ST_ADD3  = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	function automatic logic signed [DATA_W-1:0] soften(input logic signed [DATA_W-1:0] e,
			input logic [LIM_W-1:0] db);
		logic signed [32:0] ex, dx;
		logic signed [DATA_W-1:0] r;
		ex = {e[DATA_W-1], e};
		dx = {2'b0, db};
		if (db == '0)
			r = e;
		else if (ex > dx)
			r = DATA_W'(ex - dx);
		else if (ex < -dx)
			r = DATA_W'(ex + dx);
		else
			r = '0;
		return r;
	endfunction

	logic [3:0] state_q;
	logic [2:0] step_q;
	logic [2:0] k_q;

	logic signed [DATA_W-1:0] prev_q, older_q, isum_q, lastinc_q;

	logic signed [32:0]       diff_q;
	logic [DT_W-1:0]          dt_q;
	logic [31:0]              m_q;
	logic                     side_q;
	logic signed [DATA_W-1:0] err_q, e_now_q, e_last_q, e_older_q;
	logic signed [33:0]       pdiff_q, ddiff_q;
	logic signed [DATA_W-1:0] t1_q, pterm_q, iterm_q, dterm_q, isum_new_q;
	logic signed [33:0]       acc_q;
	res_t                     res_q;

	logic signed [33:0]       diff34;
	logic [31:0]              wsub;
	logic signed [DATA_W-1:0] wv;
	logic [DATA_W-1:0]        err_u, err_mag;
	logic                     d_off, div_go;
	logic signed [32:0]       isum_sum, ilim33;
	logic signed [33:0]       olim34, e_now34, e_last34, e_older34;
	logic signed [DATA_W-1:0] drive_new;

	logic signed [DATA_W-1:0] mul_a;
	logic signed [33:0]       mul_b;
	logic                     mul_sh24;
	logic [DATA_W-1:0]        mul_res;
	logic [63:0]              mul_prod;
	logic                     mul_neg;
	logic                     div_busy;
	logic [DATA_W-1:0]        div_res;

	always_comb begin
		diff34    = {diff_q[32], diff_q};
		wsub      = 32'(FULL_TURN) << k_q;
		wv        = DATA_W'(HALF_TURN + 34'sd1 - FULL_TURN + {2'b0, m_q});
		err_u     = err_q;
		err_mag   = err_q[DATA_W-1] ? (~err_u + 32'd1) : err_u;
		d_off     = (cfg.gain_d == '0) || (dt_q < DT_MIN);
		div_go    = (state_q == ST_MUL) && (step_q == 3'd4) && !cfg.incr && !d_off;
		isum_sum  = cfg.incr ? {iterm_q[DATA_W-1], iterm_q}
			: {isum_q[DATA_W-1], isum_q} + {iterm_q[DATA_W-1], iterm_q};
		ilim33    = {2'b0, cfg.int_lim};
		olim34    = {3'b0, cfg.out_lim};
		e_now34   = {{2{e_now_q[DATA_W-1]}}, e_now_q};
		e_last34  = {{2{e_last_q[DATA_W-1]}}, e_last_q};
		e_older34 = {{2{e_older_q[DATA_W-1]}}, e_older_q};
		if (acc_q > olim34)
			drive_new = DATA_W'(olim34);
		else if (acc_q < -olim34)
			drive_new = DATA_W'(-olim34);
		else
			drive_new = acc_q[DATA_W-1:0];
	end

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_sh24 = 1'b0;
		if (state_q == ST_MUL) begin
			case (step_q)
				3'd0: begin
					mul_a = cfg.gain_i;
					mul_b = {{2{e_now_q[DATA_W-1]}}, e_now_q};
				end
				3'd1: begin
					mul_a = cfg.gain_p;
					mul_b = pdiff_q;
				end
				3'd2: begin
					mul_a = cfg.gain_d;
					mul_b = ddiff_q;
				end
				3'd3: begin
					mul_a    = t1_q;
					mul_b    = {10'b0, dt_q};
					mul_sh24 = 1'b1;
				end
				default: ;
			endcase
		end
	end

	pcs_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.sh24 (mul_sh24),
		.res  (mul_res),
		.prod (mul_prod),
		.neg  (mul_neg)
	);

	pcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (mul_prod),
		.neg    (mul_neg),
		.den    (dt_q),
		.busy   (div_busy),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			k_q       <= '0;
			prev_q    <= '0;
			older_q   <= '0;
			isum_q    <= '0;
			lastinc_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					k_q <= 3'd7;
					if (cfg.wrap && (diff34 > HALF_TURN || diff34 < -HALF_TURN))
						state_q <= ST_WRAP;
					else
						state_q <= ST_CHECK;
				end
				ST_WRAP: begin
					k_q <= k_q - 3'd1;
					if (k_q == 3'd0)
						state_q <= ST_WFIN;
				end
				ST_WFIN: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (cfg.err_lim != '0 && err_mag > {1'b0, cfg.err_lim})
						state_q <= ST_DONE;
					else
						state_q <= ST_SOFT;
				end
				ST_SOFT: state_q <= ST_DIFF;
				ST_DIFF: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5)
						state_q <= (!cfg.incr && !d_off) ? ST_DIVW : ST_INT;
				end
				ST_DIVW: begin
					if (!div_busy)
						state_q <= ST_INT;
				end
				ST_INT:  state_q <= ST_ADD2;
				ST_ADD2: state_q <= ST_ADD3;
				ST_ADD3: state_q <= ST_FIN;
				ST_FIN: begin
					isum_q  <= isum_new_q;
					older_q <= prev_q;
					prev_q  <= err_q;
					if (cfg.incr)
						lastinc_q <= drive_new;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				diff_q <= {targ[DATA_W-1], targ} - {meas[DATA_W-1], meas};
				dt_q   <= dt;
			end
			ST_PREP: begin
				side_q <= diff34 < -HALF_TURN;
				if (diff34 > HALF_TURN)
					m_q <= 32'(diff34 - HALF_TURN - 34'sd1);
				else
					m_q <= 32'(-HALF_TURN - diff34 - 34'sd1);
				if (diff_q > 33'sh07fffffff)
					err_q <= 32'sh7fffffff;
				else if (diff_q < -33'sh080000000)
					err_q <= 32'sh80000000;
				else
					err_q <= diff_q[DATA_W-1:0];
			end
			ST_WRAP: begin
				if (m_q >= wsub)
					m_q <= m_q - wsub;
			end
			ST_WFIN: err_q <= side_q ? -wv : wv;
			ST_CHECK: begin
				res_q.drive    <= '0;
				res_q.rejected <= 1'b1;
			end
			ST_SOFT: begin
				e_now_q   <= soften(err_q, cfg.db_width);
				e_last_q  <= soften(prev_q, cfg.db_width);
				e_older_q <= soften(older_q, cfg.db_width);
			end
			ST_DIFF: begin
				pdiff_q <= cfg.incr ? e_now34 - e_last34 : e_now34;
				ddiff_q <= cfg.incr ? e_now34 - e_last34 - e_last34 + e_older34
					: e_now34 - e_last34;
			end
			ST_MUL: begin
				case (step_q)
					3'd2: t1_q <= mul_res;
					3'd3: pterm_q <= mul_res;
					3'd4: dterm_q <= cfg.incr ? mul_res : '0;
					3'd5: iterm_q <= mul_res;
					default: ;
				endcase
			end
			ST_DIVW: dterm_q <= div_res;
			ST_INT: begin
				if (isum_sum > ilim33)
					isum_new_q <= DATA_W'(ilim33);
				else if (isum_sum < -ilim33)
					isum_new_q <= DATA_W'(-ilim33);
				else
					isum_new_q <= isum_sum[DATA_W-1:0];
				acc_q <= (cfg.incr ? {{2{lastinc_q[DATA_W-1]}}, lastinc_q} : 34'sd0)
					+ {{2{pterm_q[DATA_W-1]}}, pterm_q};
			end
			ST_ADD2: acc_q <= acc_q + {{2{isum_new_q[DATA_W-1]}}, isum_new_q};
			ST_ADD3: acc_q <= acc_q + {{2{dterm_q[DATA_W-1]}}, dterm_q};
			ST_FIN: ;
			ST_DONE: ;
			default: ;
		endcase
		if (state_q == ST_ADD3) begin
			res_q.rejected <= 1'b0;
		end
		if (state_q == ST_FIN) begin
			res_q.drive <= drive_new;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;
	assign res       = res_q;

endmodule

// ===== src/pid_controller_step_core.sv =====
// PID controller step in Q16.16. Each input beat (measurement, setpoint,
// time step) gives one output beat. In positional mode with the derivative
// on, the 32-step restoring divider that forms gain_d*(e - e_prev)/dt runs
// before the output beat appears, unless the quotient overflows and
// saturates at once; incremental mode and a derivative that is off skip it.
// Angle wrapping adds the eight-step modulo-360 reduction, and a rejected
// beat skips the computation. Four products share one two-stage 32x34
// multiplier. The next beat can be taken in the cycle after the current one
// moves into the output register. Registers must be written only while the
// block is idle; the block itself does not enforce this.
module pid_controller_step_core import pcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // measured_value, target_value, time_step
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // drive_value
	output logic [0:0]  m_axis_tuser,  // rejected
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	cfg_t        cfg_q;
	logic        out_valid_q;
	logic [31:0] out_drive_q;
	logic        out_rej_q;
	logic        res_valid, res_ready;
	res_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FLAGS: begin
					cfg_q.incr <= wr_data[0];
					cfg_q.wrap <= wr_data[1];
				end
				REG_GAIN_P:   cfg_q.gain_p   <= wr_data;
				REG_GAIN_I:   cfg_q.gain_i   <= wr_data;
				REG_GAIN_D:   cfg_q.gain_d   <= wr_data;
				REG_INT_LIM:  cfg_q.int_lim  <= wr_data[LIM_W-1:0];
				REG_OUT_LIM:  cfg_q.out_lim  <= wr_data[LIM_W-1:0];
				REG_DB_WIDTH: cfg_q.db_width <= wr_data[LIM_W-1:0];
				REG_ERR_LIM:  cfg_q.err_lim  <= wr_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	pcs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.meas      (s_axis_tdata[31:0]),
		.targ      (s_axis_tdata[63:32]),
		.dt        (s_axis_tdata[87:64]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			out_drive_q <= res.drive;
			out_rej_q   <= res.rejected;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_drive_q;
	assign m_axis_tuser[0] = out_rej_q;

endmodule
